[rtl/core/alu8_pkg.sv]
// Package for the 8-bit ALU: operation codes, request/response types and the datapath function.
`default_nettype none

package alu8_pkg;

  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_RLC  = 5'd8,
    ACT_RRC  = 5'd9,
    ACT_RL   = 5'd10,
    ACT_RR   = 5'd11,
    ACT_SLA  = 5'd12,
    ACT_SRA  = 5'd13,
    ACT_SWAP = 5'd14,
    ACT_SRL  = 5'd15,
    ACT_BIT  = 5'd16,
    ACT_RES  = 5'd17,
    ACT_SET  = 5'd18,
    ACT_DAA  = 5'd19,
    ACT_CPL  = 5'd20,
    ACT_SCF  = 5'd21,
    ACT_CCF  = 5'd22,
    ACT_RLCA = 5'd23,
    ACT_RRCA = 5'd24,
    ACT_RLA  = 5'd25,
    ACT_RRA  = 5'd26,
    ACT_INC  = 5'd27,
    ACT_DEC  = 5'd28
  } action_t;

  // decimal adjust constants
  localparam logic [8:0] DAA_HIGH_LIMIT = 9'h09F;
  localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
  localparam logic [3:0] DAA_LOW_LIMIT  = 4'd9;

  typedef struct packed {
    logic [4:0] action;
    logic [7:0] accumulator;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_result;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
  } alu_rsp_t;

  function automatic alu_rsp_t alu_eval(input alu_req_t req);
    alu_rsp_t   rsp;
    logic [7:0] a;
    logic [7:0] v;
    logic       t;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [8:0] daa;
    logic       setz;
    a    = req.accumulator;
    v    = req.operand;
    t    = 1'b0;
    wide = 9'd0;
    nib  = 5'd0;
    daa  = 9'd0;
    setz = 1'b1;
    rsp.result       = a;
    rsp.write_result = 1'b1;
    rsp.z            = req.z;
    rsp.n            = req.n;
    rsp.h            = req.h;
    rsp.c            = req.c;
    case (req.action)
      ACT_ADD, ACT_ADC: begin
        t    = (req.action == ACT_ADC) ? req.c : 1'b0;
        wide = {1'b0, a} + {1'b0, v} + {8'd0, t};
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
        rsp.result = wide[7:0];
        rsp.c = wide[8];
        rsp.h = nib[4];
        rsp.n = 1'b0;
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        t    = (req.action == ACT_SBC) ? req.c : 1'b0;
        wide = {1'b0, a} - {1'b0, v} - {8'd0, t};
        nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
        rsp.result = wide[7:0];
        rsp.c = wide[8];   // borrow
        rsp.h = nib[4];
        rsp.n = 1'b1;
        if (req.action == ACT_CP) begin
          rsp.write_result = 1'b0;
        end
      end
      ACT_AND: begin
        rsp.result = a & v;
        rsp.n = 1'b0;
        rsp.h = 1'b1;
        rsp.c = 1'b0;
      end
      ACT_XOR: begin
        rsp.result = a ^ v;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        rsp.c = 1'b0;
      end
      ACT_OR: begin
        rsp.result = a | v;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        rsp.c = 1'b0;
      end
      ACT_RLC: begin
        rsp.result = {v[6:0], v[7]};
        rsp.c = v[7];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_RRC: begin
        rsp.result = {v[0], v[7:1]};
        rsp.c = v[0];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_RL: begin
        rsp.result = {v[6:0], req.c};
        rsp.c = v[7];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_RR: begin
        rsp.result = {req.c, v[7:1]};
        rsp.c = v[0];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_SLA: begin
        rsp.result = {v[6:0], 1'b0};
        rsp.c = v[7];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_SRA: begin
        rsp.result = {v[7], v[7:1]};
        rsp.c = v[0];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_SWAP: begin
        rsp.result = {v[3:0], v[7:4]};
        rsp.c = 1'b0;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_SRL: begin
        rsp.result = {1'b0, v[7:1]};
        rsp.c = v[0];
        rsp.n = 1'b0;
        rsp.h = 1'b0;
      end
      ACT_BIT: begin
        rsp.result = v;
        rsp.write_result = 1'b0;
        setz  = 1'b0;
        rsp.z = ~v[req.bit_index];
        rsp.n = 1'b0;
        rsp.h = 1'b1;
      end
      ACT_RES: begin
        rsp.result = v & ~(8'd1 << req.bit_index);
        setz = 1'b0;
      end
      ACT_SET: begin
        rsp.result = v | (8'd1 << req.bit_index);
        setz = 1'b0;
      end
      ACT_DAA: begin
        daa = {1'b0, a};
        if (req.n) begin
          if (req.h) begin
            daa = {1'b0, daa[7:0] - DAA_LOW_ADJ};
          end
          if (req.c) begin
            daa = {1'b0, daa[7:0] - DAA_HIGH_ADJ};
          end
        end else begin
          if (req.h || (daa[3:0] > DAA_LOW_LIMIT)) begin
            daa = daa + {1'b0, DAA_LOW_ADJ};
          end
          if (req.c || (daa > DAA_HIGH_LIMIT)) begin
            daa = daa + {1'b0, DAA_HIGH_ADJ};
          end
        end
        rsp.result = daa[7:0];
        rsp.c = req.c | daa[8];
        rsp.h = 1'b0;
      end
      ACT_CPL: begin
        rsp.result = ~a;
        rsp.n = 1'b1;
        rsp.h = 1'b1;
        setz  = 1'b0;
      end
      ACT_SCF: begin
        rsp.c = 1'b1;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_CCF: begin
        rsp.c = ~req.c;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_RLCA: begin
        rsp.result = {a[6:0], a[7]};
        rsp.c = a[7];
        rsp.z = 1'b0;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_RRCA: begin
        rsp.result = {a[0], a[7:1]};
        rsp.c = a[0];
        rsp.z = 1'b0;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_RLA: begin
        rsp.result = {a[6:0], req.c};
        rsp.c = a[7];
        rsp.z = 1'b0;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_RRA: begin
        rsp.result = {req.c, a[7:1]};
        rsp.c = a[0];
        rsp.z = 1'b0;
        rsp.n = 1'b0;
        rsp.h = 1'b0;
        setz  = 1'b0;
      end
      ACT_INC: begin
        rsp.result = v + 8'd1;
        rsp.h = (v[3:0] == 4'hF);
        rsp.n = 1'b0;
      end
      ACT_DEC: begin
        rsp.result = v - 8'd1;
        rsp.h = (v[3:0] == 4'h0);
        rsp.n = 1'b1;
      end
      default: begin
        // undefined codes: no store, flags untouched
        rsp.write_result = 1'b0;
        setz = 1'b0;
      end
    endcase
    if (setz) begin
      rsp.z = (rsp.result == 8'd0);
    end
    return rsp;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cpu_eight_bit_alu_with_flags_unit.sv]
// Top level of the 8-bit ALU with flags: request register, datapath, result register.
`default_nettype none

// 8-bit ALU with flags. Each request carries an operation code, the
// accumulator, a second operand, a bit index and the four incoming flags
// (zero, subtract, half carry, carry); each request yields exactly one
// response with the result byte, a store enable (low for compare, bit test
// and undefined codes) and the four new flags. Throughput is one request
// per clock while out_ready stays high. The request register loads at the
// accepting edge and the result register loads from it when the output can
// advance; out_valid then holds the response until out_ready takes it. The
// whole datapath (9-bit add/subtract plus decimal-adjust and flag
// muxing) sits between the two registers. Both stages advance
// independently, so a request is still taken while a finished response
// waits on out_ready; input stalls only when both stages are full and the
// output is held. No configuration, no internal state beyond the pipeline.

module cpu_eight_bit_alu_with_flags_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [4:0] action,
  input  wire logic [7:0] accumulator,
  input  wire logic [7:0] operand,
  input  wire logic [2:0] bit_index,
  input  wire logic       zero_in,
  input  wire logic       subtract_in,
  input  wire logic       half_carry_in,
  input  wire logic       carry_in,
  // response channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      result,
  output logic            write_result,
  output logic            zero_out,
  output logic            subtract_out,
  output logic            half_carry_out,
  output logic            carry_out
);

  // stage 1: captured request
  alu8_pkg::alu_req_t req;
  logic               req_valid;

  // stage 2: registered response
  alu8_pkg::alu_rsp_t rsp;
  alu8_pkg::alu_rsp_t rsp_next;

  logic advance;  // stage 1 may move into the result register

  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;

  // all ALU work happens here, between the two registers
  assign rsp_next = alu8_pkg::alu_eval(req);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= req_valid;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.action      <= action;
      req.accumulator <= accumulator;
      req.operand     <= operand;
      req.bit_index   <= bit_index;
      req.z           <= zero_in;
      req.n           <= subtract_in;
      req.h           <= half_carry_in;
      req.c           <= carry_in;
    end
    if (advance && req_valid) begin
      rsp <= rsp_next;
    end
  end

  assign result         = rsp.result;
  assign write_result   = rsp.write_result;
  assign zero_out       = rsp.z;
  assign subtract_out   = rsp.n;
  assign half_carry_out = rsp.h;
  assign carry_out      = rsp.c;

`ifndef NO_ASSERTIONS
  // a held response must keep the captured request parked in stage 1
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    req_valid && out_valid && !out_ready |=> req_valid)
    else $error("request lost while response stalled");

  // full pipeline with stalled output must not take a new request
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request accepted into full pipeline");

  // a ready stage 1 request always lands in the result register
  a_stage1_moves: assert property (@(posedge clk) disable iff (rst)
    req_valid && advance |=> out_valid)
    else $error("request dropped between stages");
`endif

endmodule

`default_nettype wire
